FILE: rtl/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash table
// Concurrent checks that disappear when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpht: assertion failed");
// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpht: assertion failed");
`else
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probing hash table package
// Sizes, codes and the probe token that walks the ring of slot cells.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// table size; a power of two so the home slot is the low key bits
	localparam int SLOTS        = 16;
	localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KEY_W        = 16;
	localparam int DATA_W       = 32;
	localparam int SLOT_FIELD_W = 4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY   = 2'd0,
		SLOT_USED    = 2'd1,
		SLOT_DELETED = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		RES_INSERTED  = 2'd0,
		RES_REMOVED   = 2'd1,
		RES_NOT_FOUND = 2'd2,
		RES_FULL      = 2'd3
	} result_t;

	// probe token; data is the insert payload, later the removed payload
	typedef struct packed {
		logic                valid;
		logic                done;
		op_t                 op;
		result_t             res;
		logic [KEY_W-1:0]    key;
		logic [DATA_W-1:0]   data;
		idx_t                lap;
		idx_t                res_idx;
	} token_t;

	// new-item injection broadcast to all cells
	typedef struct packed {
		logic   go;
		idx_t   home;
		token_t tok;
	} inject_t;

	// home slot: key modulo table size
	function automatic idx_t home_of(logic [KEY_W-1:0] key);
		logic [31:0] rem;
		rem = 32'(key) % 32'(SLOTS);
		return rem[IDX_W-1:0];
	endfunction

	// slot number as reported on the 4-bit result field
	function automatic logic [SLOT_FIELD_W-1:0] slot_field(idx_t idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[SLOT_FIELD_W-1:0];
	endfunction

endpackage

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probing hash table
// Open-addressing table of SLOTS slots with insert and remove by key.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and the result
// appears on status, slot_index and removed_payload for a single cycle
// with done high; it cannot be held off, so capture it then. Each slot is
// a cell in a ring, and the item travels as a token one cell per clock
// from its home slot (key modulo SLOTS), probing as it goes, then on to
// the exit after the last cell. The time from accept to done is set by
// that walk: from the home cell on to the last cell, with one more full
// lap of the ring when it wraps. busy drops with done, so the next start
// may be given in the done cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table import lpht_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    operation,
	input  logic [KEY_W-1:0]        key,
	input  logic [DATA_W-1:0]       payload,
	output logic                    done,
	output logic [1:0]              status,
	output logic [SLOT_FIELD_W-1:0] slot_index,
	output logic [DATA_W-1:0]       removed_payload
);

	logic                    busy_q;
	logic                    done_q;
	logic                    accept;
	logic                    exit;
	inject_t                 inj;
	token_t                  chain [SLOTS];
	token_t                  wrap_tok;
	logic [SLOTS-1:0]        hold_vec;
	result_t                 status_q;
	logic [SLOT_FIELD_W-1:0] slot_index_q;
	logic [DATA_W-1:0]       removed_payload_q;

	assign accept = start && !busy_q;

	// new token, placed on its home cell
	always_comb begin
		inj.go          = accept;
		inj.home        = home_of(key);
		inj.tok         = '0;
		inj.tok.valid   = 1'b1;
		inj.tok.done    = 1'b0;
		inj.tok.op      = op_t'(operation);
		inj.tok.res     = RES_INSERTED;
		inj.tok.key     = key;
		inj.tok.data    = payload;
		inj.tok.lap     = '0;
		inj.tok.res_idx = '0;
	end

	// finished tokens leave the ring after the last cell
	assign exit = chain[SLOTS-1].valid && chain[SLOTS-1].done;
	always_comb begin
		wrap_tok       = chain[SLOTS-1];
		wrap_tok.valid = chain[SLOTS-1].valid && !chain[SLOTS-1].done;
	end

	// ring of slot cells
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		token_t prev_tok;
		if (g == 0) begin : g_head
			assign prev_tok = wrap_tok;
		end else begin : g_body
			assign prev_tok = chain[g-1];
		end
		lpht_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (idx_t'(g)),
			.inj      (inj),
			.prev     (prev_tok),
			.tok_next (chain[g]),
			.holding  (hold_vec[g])
		);
	end

	// control: busy from accept until the result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= exit;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exit) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (exit) begin
			status_q          <= chain[SLOTS-1].res;
			slot_index_q      <= slot_field(chain[SLOTS-1].res_idx);
			removed_payload_q <= chain[SLOTS-1].data;
		end
	end

	assign busy            = busy_q;
	assign done            = done_q;
	assign status          = status_q;
	assign slot_index      = slot_index_q;
	assign removed_payload = removed_payload_q;

	// checks
	`LPHT_ASSERT_IMPL(a_one_token_while_busy, clk, arst_n, 1'b1, busy_q == $onehot(hold_vec))
	`LPHT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy_q)
	`LPHT_ASSERT_IMPL(a_idle_on_result, clk, arst_n, done_q, !busy_q)
	`LPHT_ASSERT_NEXT(a_single_strobe, clk, arst_n, done_q, !done_q)

endmodule

FILE: rtl/lpht_cell.sv
// ----------------------------------------------------------------------------
// Hash table slot cell
// Holds one slot, checks the probe token passing through and hands it on.
// ----------------------------------------------------------------------------
module lpht_cell import lpht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  idx_t    cell_idx,
	input  inject_t inj,
	input  token_t  prev,
	output token_t  tok_next,
	output logic    holding
);

	slot_state_t       state_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	token_t            tok_q;
	logic              wr_used;
	logic              wr_del;
	logic              last_lap;

	// token register: new item lands on its home cell, otherwise shift in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (inj.go && (inj.home == cell_idx)) begin
			tok_q <= inj.tok;
		end else begin
			tok_q <= prev;
		end
	end

	assign holding  = tok_q.valid;
	assign last_lap = (tok_q.lap == idx_t'(SLOTS - 1));

	// probe step against this slot
	always_comb begin
		tok_next = tok_q;
		wr_used  = 1'b0;
		wr_del   = 1'b0;
		if (tok_q.valid && !tok_q.done) begin
			case (tok_q.op)
				OP_INSERT: begin
					if (state_q == SLOT_EMPTY || state_q == SLOT_DELETED) begin
						wr_used          = 1'b1;
						tok_next.done    = 1'b1;
						tok_next.res     = RES_INSERTED;
						tok_next.res_idx = cell_idx;
						tok_next.data    = '0;
					end else if (last_lap) begin
						tok_next.done    = 1'b1;
						tok_next.res     = RES_FULL;
						tok_next.res_idx = '0;
						tok_next.data    = '0;
					end else begin
						tok_next.lap = tok_q.lap + idx_t'(1);
					end
				end
				OP_REMOVE: begin
					if (state_q == SLOT_EMPTY) begin
						tok_next.done    = 1'b1;
						tok_next.res     = RES_NOT_FOUND;
						tok_next.res_idx = '0;
						tok_next.data    = '0;
					end else if (state_q != SLOT_DELETED && key_q == tok_q.key) begin
						wr_del           = 1'b1;
						tok_next.done    = 1'b1;
						tok_next.res     = RES_REMOVED;
						tok_next.res_idx = cell_idx;
						tok_next.data    = data_q;
					end else if (last_lap) begin
						tok_next.done    = 1'b1;
						tok_next.res     = RES_NOT_FOUND;
						tok_next.res_idx = '0;
						tok_next.data    = '0;
					end else begin
						tok_next.lap = tok_q.lap + idx_t'(1);
					end
				end
				default: tok_next = tok_q;
			endcase
		end
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SLOT_EMPTY;
		end else if (wr_used) begin
			state_q <= SLOT_USED;
		end else if (wr_del) begin
			state_q <= SLOT_DELETED;
		end
	end

	// slot contents, only read while the slot is occupied
	always_ff @(posedge clk) begin
		if (wr_used) begin
			key_q  <= tok_q.key;
			data_q <= tok_q.data;
		end
	end

endmodule

FILE: sim/linear_probe_hash_table_tb.sv
// ----------------------------------------------------------------------------
// Linear probing hash table testbench
// Drives inserts and removes through the start/busy transfer and checks
// every strobed result against a local model of the slot table or, for a
// typed row, its own result. A short table of directed items comes first,
// then mostly valid random sequences in three phases of different idling.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb import lpht_pkg::*;;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;

	typedef struct {
		result_t                 status;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [DATA_W-1:0]       rpay;
	} hash_result_t;

	// directed row; typed rows carry their own expected result
	typedef struct {
		op_t               op;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] p;
		int                reps;
		bit                typed;
		result_t           status;
		logic [3:0]        slot;
		logic [DATA_W-1:0] rpay;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    operation;
	logic [KEY_W-1:0]        key;
	logic [DATA_W-1:0]       payload;
	logic                    done;
	logic [1:0]              status;
	logic [SLOT_FIELD_W-1:0] slot_index;
	logic [DATA_W-1:0]       removed_payload;

	// model of the table
	slot_state_t       table_state[SLOTS];
	logic [KEY_W-1:0]  table_key[SLOTS];
	logic [DATA_W-1:0] table_data[SLOTS];

	hash_result_t      pending_results[$];
	logic [KEY_W-1:0]  live_keys[$];
	int                errors = 0;
	int                idle_pct = 0;
	int                stall_cycles = 0;

	linear_probe_hash_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.key             (key),
		.payload         (payload),
		.done            (done),
		.status          (status),
		.slot_index      (slot_index),
		.removed_payload (removed_payload)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// apply one operation to the model table and return its result
	function automatic hash_result_t probe_table(op_t op, logic [KEY_W-1:0] k,
			logic [DATA_W-1:0] p);
		hash_result_t r;
		int           idx;
		idx = int'(k) % SLOTS;
		r.status = (op == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
		r.slot = '0;
		r.rpay = '0;
		for (int n = 0; n < SLOTS; n++) begin
			if (op == OP_INSERT) begin
				if (table_state[idx] == SLOT_EMPTY || table_state[idx] == SLOT_DELETED) begin
					table_state[idx] = SLOT_USED;
					table_key[idx] = k;
					table_data[idx] = p;
					r.status = RES_INSERTED;
					r.slot = SLOT_FIELD_W'(idx);
					return r;
				end
			end else begin
				// an empty slot ends the chain; deleted slots are skipped
				if (table_state[idx] == SLOT_EMPTY)
					return r;
				if (table_state[idx] != SLOT_DELETED && table_key[idx] == k) begin
					table_state[idx] = SLOT_DELETED;
					r.status = RES_REMOVED;
					r.slot = SLOT_FIELD_W'(idx);
					r.rpay = table_data[idx];
					return r;
				end
			end
			idx = (idx + 1) % SLOTS;
		end
		return r;
	endfunction

	// one transfer, with a random idle gap ahead of it
	task automatic send_item(op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] p,
			bit typed, hash_result_t typed_res);
		hash_result_t predicted;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		start     <= 1'b1;
		operation <= op;
		key       <= k;
		payload   <= p;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = probe_table(op, k, p);
		if (predicted.status == RES_INSERTED)
			live_keys.push_back(k);
		if (predicted.status == RES_REMOVED) begin
			foreach (live_keys[i]) begin
				if (live_keys[i] == k) begin
					live_keys.delete(i);
					break;
				end
			end
		end
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// stop sending until every expected result has arrived
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// keys clustered on a few high patterns so probe chains form
	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: k[KEY_W-1:4] = '0;
			1: k[KEY_W-1:4] = '1;
			2: k[KEY_W-1:4] = 12'($urandom_range(1, 3));
			default: ;
		endcase
		return k;
	endfunction

	task automatic run_random(int count);
		op_t               op;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] p;
		int                ins_pct;
		hash_result_t      none;
		none = '{RES_INSERTED, '0, '0};
		for (int i = 0; i < count; i++) begin
			ins_pct = (live_keys.size() >= 12) ? 35 : 60;
			op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
			if (op == OP_REMOVE && live_keys.size() > 0 && $urandom_range(0, 99) < 80)
				k = live_keys[$urandom_range(0, live_keys.size() - 1)];
			else
				k = pick_key();
			case ($urandom_range(0, 7))
				0: p = '0;
				1: p = '1;
				default: p = $urandom();
			endcase
			send_item(op, k, p, 1'b0, none);
		end
	endtask

	// result check and watchdog
	always @(posedge clk) begin : check_results
		hash_result_t want;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: status %0d slot %0d payload %h",
						$time, status, slot_index, removed_payload);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
					if (slot_index !== want.slot) begin
						errors++;
						$display("%0t: slot_index expected %0d actual %0d",
							$time, want.slot, slot_index);
					end
					if (removed_payload !== want.rpay) begin
						errors++;
						$display("%0t: removed_payload expected %h actual %h",
							$time, want.rpay, removed_payload);
					end
				end
			end
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("linear_probe_hash_table_tb failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t    directed_rows[13];
		hash_result_t typed_res;
		foreach (table_state[i]) begin
			table_state[i] = SLOT_EMPTY;
			table_key[i] = '0;
			table_data[i] = '0;
		end
		arst_n    = 1'b0;
		start     = 1'b0;
		operation = OP_INSERT;
		key       = '0;
		payload   = '0;

		directed_rows = '{
			// empty table: nothing to find
			'{OP_REMOVE, 16'h0005, 32'h0000_0000, 1, 1'b1, RES_NOT_FOUND, 4'd0, 32'h0},
			// lowest and highest key and payload
			'{OP_INSERT, 16'h0000, 32'h0000_0000, 1, 1'b1, RES_INSERTED, 4'd0, 32'h0},
			'{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, RES_INSERTED, 4'd15, 32'h0},
			// collision on home slot 0, then a duplicate key
			'{OP_INSERT, 16'h0010, 32'h1234_5678, 1, 1'b0, RES_INSERTED, 4'd0, 32'h0},
			'{OP_INSERT, 16'h0000, 32'hA5A5_A5A5, 1, 1'b0, RES_INSERTED, 4'd0, 32'h0},
			'{OP_REMOVE, 16'h0000, 32'hFFFF_FFFF, 1, 1'b1, RES_REMOVED, 4'd0, 32'h0},
			// search passes the deleted slot 0
			'{OP_REMOVE, 16'h0010, 32'h0000_0000, 1, 1'b0, RES_INSERTED, 4'd0, 32'h0},
			'{OP_REMOVE, 16'h0000, 32'h0000_0000, 1, 1'b0, RES_INSERTED, 4'd0, 32'h0},
			'{OP_REMOVE, 16'hFFFF, 32'h0000_0000, 1, 1'b1, RES_REMOVED, 4'd15, 32'hFFFF_FFFF},
			// fill every slot, reusing deleted ones, wrapping past the end
			'{OP_INSERT, 16'h0007, 32'h5555_AAAA, 16, 1'b0, RES_INSERTED, 4'd0, 32'h0},
			// full table: insert fails, search runs a whole lap
			'{OP_INSERT, 16'h0009, 32'h0F0F_0F0F, 1, 1'b1, RES_FULL, 4'd0, 32'h0},
			'{OP_REMOVE, 16'h1234, 32'h0000_0000, 1, 1'b1, RES_NOT_FOUND, 4'd0, 32'h0},
			'{OP_REMOVE, 16'h0007, 32'h0000_0000, 1, 1'b0, RES_INSERTED, 4'd0, 32'h0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items back to back
		foreach (directed_rows[r]) begin
			typed_res = '{directed_rows[r].status, directed_rows[r].slot,
				directed_rows[r].rpay};
			for (int n = 0; n < directed_rows[r].reps; n++)
				send_item(directed_rows[r].op, directed_rows[r].k, directed_rows[r].p,
					directed_rows[r].typed, typed_res);
		end
		drain_results();

		// random traffic: light sender idling, heavy idling, none
		idle_pct = 14;
		run_random(270);
		drain_results();
		idle_pct = 61;
		run_random(270);
		drain_results();
		idle_pct = 0;
		run_random(260);
		drain_results();

		if (errors == 0)
			$display("linear_probe_hash_table_tb passed");
		else
			$display("linear_probe_hash_table_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_cell.sv
rtl/linear_probe_hash_table.sv
sim/linear_probe_hash_table_tb.sv
